>>> rtl/wet_pkg.sv
`timescale 1ns / 1ps

package wet_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IN_IDX_W    = 6;
    localparam int CMP_W       = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;
    localparam int ADDR_W      = 32;
    localparam int WIDTH_W     = 2;
    localparam int SLOT_W      = 5;
    localparam int COUNT_W     = 6;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [WIDTH_W-1:0] WIDTH_BAD = 2'd3;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_PRESENT = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_RANGE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [WIDTH_W-1:0] width;
    } entry_t;

endpackage

>>> rtl/watch_entry_table.sv
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// in        in_valid / in_stall  kind, watch_address, access_width, slot_index
// out       out_valid / out_stall status, slot, entry_address, entry_width, entry_count
//
// One request at a time; entry memory has one read and one write port, registered read.
// Work done per request:
// Add: one read and compare a cycle, pipelined by one; a hit ends early.
// Remove: one entry moved down a cycle. Read: one memory read. Clear: sets the count to zero;
// remove or read with an index out of range: no memory access.
// Reset empties the table at once; no clearing pass over the memory.
// in_stall is high while a request is in work; a held result waits in the output
// register, and the next request is taken while it waits.

module watch_entry_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   kind,
    input  logic [wet_pkg::ADDR_W-1:0]   watch_address,
    input  logic [wet_pkg::WIDTH_W-1:0]  access_width,
    input  logic [wet_pkg::IN_IDX_W-1:0] slot_index,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [wet_pkg::SLOT_W-1:0]   slot,
    output logic [wet_pkg::ADDR_W-1:0]   entry_address,
    output logic [wet_pkg::WIDTH_W-1:0]  entry_width,
    output logic [wet_pkg::COUNT_W-1:0]  entry_count
);

    wet_pkg::state_t                state_reg, state_next;
    logic [wet_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [wet_pkg::CNT_W-1:0]      ptr_reg, ptr_next;
    logic [wet_pkg::CNT_W-1:0]      pidx_reg, pidx_next;
    logic                           pend_reg, pend_next;
    logic                           out_valid_reg, out_valid_next;

    wet_pkg::entry_t                key_reg, key_next;
    wet_pkg::status_t               res_status_reg, res_status_next;
    logic [wet_pkg::CNT_W-1:0]      res_slot_reg, res_slot_next;
    wet_pkg::entry_t                res_entry_reg, res_entry_next;
    wet_pkg::status_t               out_status_reg, out_status_next;
    logic [wet_pkg::SLOT_W-1:0]     out_slot_reg, out_slot_next;
    wet_pkg::entry_t                out_entry_reg, out_entry_next;
    logic [wet_pkg::COUNT_W-1:0]    out_count_reg, out_count_next;

    wet_pkg::entry_t                mem [wet_pkg::MAX_ENTRIES];
    wet_pkg::entry_t                rd_data_reg;
    logic                           rd_en;
    logic [wet_pkg::IDX_W-1:0]      rd_addr;
    logic                           wr_en;
    logic [wet_pkg::IDX_W-1:0]      wr_addr;
    wet_pkg::entry_t                wr_data;

    logic                           accept;
    logic                           idx_range;
    logic                           match;
    logic [wet_pkg::CNT_W-1:0]      ptr_inc;

    assign in_stall      = (state_reg != wet_pkg::ST_IDLE);
    assign accept        = in_valid && (state_reg == wet_pkg::ST_IDLE);
    assign idx_range     = wet_pkg::CMP_W'(slot_index) >= wet_pkg::CMP_W'(count_reg);
    assign match         = pend_reg && (rd_data_reg == key_reg);
    assign ptr_inc       = ptr_reg + wet_pkg::CNT_W'(1);

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign slot          = out_slot_reg;
    assign entry_address = out_entry_reg.addr;
    assign entry_width   = out_entry_reg.width;
    assign entry_count   = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pidx_next       = pidx_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_entry_next  = res_entry_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_entry_next  = out_entry_reg;
        out_count_next  = out_count_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = key_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            wet_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = wet_pkg::STAT_OK;
                    res_slot_next   = '0;
                    res_entry_next  = '0;
                    pend_next       = 1'b0;
                    key_next.addr   = watch_address;
                    key_next.width  = (access_width == wet_pkg::WIDTH_BAD) ? '0 : access_width;
                    case (kind)
                        wet_pkg::KIND_ADD:
                        begin
                            ptr_next   = '0;
                            state_next = wet_pkg::ST_SEARCH;
                        end
                        wet_pkg::KIND_REMOVE:
                        begin
                            if (idx_range)
                            begin
                                res_status_next = wet_pkg::STAT_RANGE;
                                state_next      = wet_pkg::ST_DONE;
                            end
                            else
                            begin
                                ptr_next   = wet_pkg::CNT_W'(slot_index);
                                state_next = wet_pkg::ST_SHIFT;
                            end
                        end
                        wet_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                            state_next = wet_pkg::ST_DONE;
                        end
                        default:
                        begin
                            if (idx_range)
                            begin
                                res_status_next = wet_pkg::STAT_RANGE;
                                state_next      = wet_pkg::ST_DONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = wet_pkg::IDX_W'(slot_index);
                                state_next = wet_pkg::ST_READ;
                            end
                        end
                    endcase
                end
            end

            wet_pkg::ST_SEARCH:
            begin
                if (match)
                begin
                    res_status_next = wet_pkg::STAT_PRESENT;
                    res_slot_next   = pidx_reg;
                    state_next      = wet_pkg::ST_DONE;
                end
                else if (ptr_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ptr_reg[wet_pkg::IDX_W-1:0];
                    pidx_next = ptr_reg;
                    pend_next = 1'b1;
                    ptr_next  = ptr_inc;
                end
                else if (count_reg == wet_pkg::CNT_W'(wet_pkg::MAX_ENTRIES))
                begin
                    res_status_next = wet_pkg::STAT_FULL;
                    state_next      = wet_pkg::ST_DONE;
                end
                else
                begin
                    // append the new pair
                    wr_en         = 1'b1;
                    wr_addr       = count_reg[wet_pkg::IDX_W-1:0];
                    wr_data       = key_reg;
                    res_slot_next = count_reg;
                    count_next    = count_reg + wet_pkg::CNT_W'(1);
                    state_next    = wet_pkg::ST_DONE;
                end
            end

            wet_pkg::ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pidx_reg[wet_pkg::IDX_W-1:0];
                    wr_data = rd_data_reg;
                end
                if (ptr_inc < count_reg)
                begin
                    // fetch the next entry, move it down one place next cycle
                    rd_en     = 1'b1;
                    rd_addr   = ptr_inc[wet_pkg::IDX_W-1:0];
                    pidx_next = ptr_reg;
                    pend_next = 1'b1;
                    ptr_next  = ptr_inc;
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = count_reg - wet_pkg::CNT_W'(1);
                    state_next = wet_pkg::ST_DONE;
                end
            end

            wet_pkg::ST_READ:
            begin
                res_entry_next = rd_data_reg;
                state_next     = wet_pkg::ST_DONE;
            end

            wet_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = wet_pkg::SLOT_W'(res_slot_reg);
                    out_entry_next  = res_entry_reg;
                    out_count_next  = wet_pkg::COUNT_W'(count_reg);
                    state_next      = wet_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = wet_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wet_pkg::ST_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            pidx_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pidx_reg      <= pidx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_entry_reg  <= res_entry_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_entry_reg  <= out_entry_next;
        out_count_reg  <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule
